@@ src/assert_macros.svh @@
// Assertion macros used by the top level of the smoothing filter.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle; disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle; disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ src/tsof_pkg.sv @@
// Package of the system-temperature smoothing filter: widths, constants,
// payload structs and the sequencer state type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tsof_pkg;

    // Default parameter values.
    localparam int CHANNELS_DEF   = 512;
    localparam int JUMP_LIMIT_DEF = 6;

    // Field widths.
    localparam int CH_W       = 9;
    localparam int T_W        = 32;
    localparam int P_W        = 16;
    localparam int CNT_W      = 16;
    localparam int SAMP_W     = 12;
    localparam int ALPHA_W    = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 34;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd2;

    // Configuration reset values.
    localparam logic [SAMP_W-1:0]  SAMPLES_RST = 12'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_RST   = 16'd6236;

    // Filter modes.
    localparam logic [MODE_W-1:0] MODE_ALWAYS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REJECT = 2'd1;

    // Sample limits in Q21.10 kelvin.
    localparam logic signed [T_W-1:0] LOW_EXCL     = -32'sd1023488;
    localparam logic signed [T_W-1:0] HIGH_INCL    = 32'sd1023948;
    localparam logic signed [T_W-1:0] MIN_ABS      = 32'sd52;
    localparam logic signed [T_W-1:0] NODATA_LIMIT = -32'sd1024000000;

    // Deviation scale (100 percent times 256) and rounding offset.
    localparam logic signed [MUL_A_W-1:0] DEV_SCALE  = 17'sd25600;
    localparam logic signed [MUL_P_W-1:0] ROUND_HALF = 51'sd32768;

    localparam logic [CNT_W-1:0] CNT_SAT = 16'hFFFF;

    typedef struct packed {
        logic [SAMP_W-1:0]  samples;
        logic [ALPHA_W-1:0] alpha;
        logic [MODE_W-1:0]  mode;
    } t_cfg;

    typedef struct packed {
        logic                  cmd;
        logic [CH_W-1:0]       channel;
        logic signed [T_W-1:0] tsys;
        logic                  no_data;
        logic signed [P_W-1:0] threshold_pct;
    } t_item;

    typedef struct packed {
        logic [CH_W-1:0]       channel_out;
        logic signed [T_W-1:0] tsys_out;
        logic [CNT_W-1:0]      clip_count;
        logic                  recovered;
    } t_res;

    // One row of per-channel state.
    typedef struct packed {
        logic signed [T_W-1:0] sv;
        logic                  val;
        logic [CNT_W-1:0]      sc;
        logic signed [T_W-1:0] hv;
        logic [CNT_W-1:0]      hc;
        logic [CNT_W-1:0]      cl;
        logic                  jm;
    } t_row;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE,
        S_D1L, S_D1R, S_D1W, S_D1C,
        S_SML, S_SMW, S_SMC,
        S_SHL, S_SHW, S_SHC,
        S_D2L, S_D2R, S_D2W, S_D2C,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ src/tsof_if.sv @@
// Channel interfaces of the smoothing filter: input items, results and
// configuration writes. Depends on tsof_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tsof_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [tsof_pkg::CH_W-1:0]        channel;
    logic signed [tsof_pkg::T_W-1:0]  tsys;
    logic                             no_data;
    logic signed [tsof_pkg::P_W-1:0]  threshold_pct;
    modport source (output valid, cmd, channel, tsys, no_data, threshold_pct, input ready);
    modport sink (input valid, cmd, channel, tsys, no_data, threshold_pct, output ready);
endinterface

interface tsof_out_if;
    logic                              valid;
    logic                              ready;
    logic [tsof_pkg::CH_W-1:0]         channel_out;
    logic signed [tsof_pkg::T_W-1:0]   tsys_out;
    logic [tsof_pkg::CNT_W-1:0]        clip_count;
    logic                              recovered;
    modport source (output valid, channel_out, tsys_out, clip_count, recovered, input ready);
    modport sink (input valid, channel_out, tsys_out, clip_count, recovered, output ready);
endinterface

interface tsof_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tsof_pkg::CFG_IDX_W-1:0]      index;
    logic [tsof_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/tsof_mul.sv @@
// Shared signed multiplier with registered operands and registered product.
// Depends on tsof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsof_mul (
    input  wire logic                                  i_clk,
    input  wire logic signed [tsof_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic signed [tsof_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [tsof_pkg::MUL_P_W-1:0]        o_p
);
    import tsof_pkg::*;

    logic signed [MUL_A_W-1:0] r_a;
    logic signed [MUL_B_W-1:0] r_b;
    logic signed [MUL_P_W-1:0] r_p;

    // Operand stage, then product stage at the full product width.
    always_ff @(posedge i_clk) begin
        r_a <= i_a;
        r_b <= i_b;
        r_p <= MUL_P_W'(r_a) * MUL_P_W'(r_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ src/tsof_seq.sv @@
// Sequencer of the smoothing filter: per-channel state memory, clearing
// pass and the step logic around the shared multiplier. Depends on
// tsof_pkg and tsof_mul.
`timescale 1ns / 1ps
`default_nettype none

module tsof_seq #(
    parameter int CHANNELS        = tsof_pkg::CHANNELS_DEF,
    parameter int JUMP_CLIP_LIMIT = tsof_pkg::JUMP_LIMIT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tsof_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire tsof_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output tsof_pkg::t_res       o_res
);
    import tsof_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_state r_state, n_state;
    t_item  r_item,  n_item;
    t_row   r_row,   n_row;
    logic signed [T_W-1:0]     r_res, n_res;
    logic                      r_rec, n_rec;
    logic                      r_chok, n_chok;
    logic                      r_rej, n_rej;
    logic signed [MUL_P_W-1:0] r_lhs, n_lhs;
    logic [AW-1:0]             r_clr;

    t_row                      mem [CHANNELS];
    t_row                      r_rd;
    logic [AW-1:0]             rd_addr;
    logic                      we;
    logic [AW-1:0]             wa;
    t_row                      wd;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    tsof_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
        return (v == CNT_SAT) ? v : v + 1'b1;
    endfunction

    function automatic logic signed [MUL_B_W-1:0] diff(input logic signed [T_W-1:0] a,
                                                       input logic signed [T_W-1:0] b);
        return MUL_B_W'(a) - MUL_B_W'(b);
    endfunction

    function automatic logic signed [MUL_B_W-1:0] absv(input logic signed [MUL_B_W-1:0] v);
        return v[MUL_B_W-1] ? -v : v;
    endfunction

    // Rounded smoothing step: base + floor((product + half) / 65536).
    function automatic logic signed [T_W-1:0] smooth_add(input logic signed [MUL_P_W-1:0] p,
                                                         input logic signed [T_W-1:0] base);
        logic signed [MUL_P_W-1:0] q;
        q = (p + ROUND_HALF) >>> 16;
        return T_W'(q + MUL_P_W'(base));
    endfunction

    // Memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[rd_addr];
    end

    assign rd_addr = AW'(i_item.channel);

    always_comb begin
        we = 1'b0;
        wa = AW'(r_item.channel);
        wd = r_row;
        if (r_state == S_CLEAR) begin
            we = 1'b1;
            wa = r_clr;
            wd = '0;
        end else if (r_state == S_DONE && i_ready && r_chok) begin
            we = 1'b1;
        end
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // State and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
        r_item <= n_item;
        r_row  <= n_row;
        r_res  <= n_res;
        r_rec  <= n_rec;
        r_chok <= n_chok;
        r_rej  <= n_rej;
        r_lhs  <= n_lhs;
    end

    // Next state, step logic and multiplier operands.
    always_comb begin
        logic inrange;
        logic dev;
        logic signed [T_W-1:0] sm;
        t_row rw;
        n_state = r_state;
        n_item  = r_item;
        n_row   = r_row;
        n_res   = r_res;
        n_rec   = r_rec;
        n_chok  = r_chok;
        n_rej   = r_rej;
        n_lhs   = r_lhs;
        mul_a   = '0;
        mul_b   = '0;
        inrange = !r_item.no_data && (r_item.tsys > LOW_EXCL) && (r_item.tsys <= HIGH_INCL);
        dev     = r_lhs >= mul_p;
        sm      = '0;
        rw      = r_rd;
        case (r_state)
            S_CLEAR: begin
                if (32'(r_clr) == CHANNELS - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_item  = i_item;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                // Apply a pending jump marker, then classify the sample.
                if (rw.jm) begin
                    rw.cl = '0;
                    rw.jm = 1'b0;
                end
                n_chok = 32'(r_item.channel) < CHANNELS;
                n_res  = r_item.tsys;
                n_rec  = 1'b0;
                n_rej  = (i_cfg.mode == MODE_REJECT) && !r_item.threshold_pct[P_W-1];
                n_state = S_DONE;
                if (!n_chok) begin
                    // A channel beyond the state memory passes straight through.
                end else if (r_item.cmd || i_cfg.samples == '0) begin
                    rw.sv  = inrange ? r_item.tsys : '0;
                    rw.val = inrange;
                    rw.sc  = inrange ? CNT_W'(1) : '0;
                    rw.cl  = '0;
                    rw.hv  = rw.sv;
                    rw.hc  = rw.sc;
                end else if (!inrange) begin
                    if (i_cfg.mode != MODE_REJECT && !r_item.no_data && rw.val &&
                        rw.sc >= CNT_W'(i_cfg.samples) && r_item.tsys > NODATA_LIMIT) begin
                        rw.cl = inc_sat(rw.cl);
                    end
                end else if (rw.val && absv(MUL_B_W'(rw.sv)) >= MUL_B_W'(MIN_ABS)) begin
                    if (n_rej) begin
                        n_state = S_D1L;
                    end else if (rw.sc < CNT_W'(i_cfg.samples) ||
                                 i_cfg.mode == MODE_ALWAYS) begin
                        n_state = S_SML;
                    end
                end else begin
                    rw.sv  = r_item.tsys;
                    rw.val = 1'b1;
                    rw.sc  = CNT_W'(1);
                    rw.cl  = '0;
                    rw.hv  = r_item.tsys;
                    rw.hc  = CNT_W'(1);
                end
                n_row = rw;
            end
            // Deviation of the sample from the estimate.
            S_D1L: begin
                mul_a   = DEV_SCALE;
                mul_b   = absv(diff(r_item.tsys, r_row.sv));
                n_state = S_D1R;
            end
            S_D1R: begin
                mul_a   = MUL_A_W'(r_item.threshold_pct);
                mul_b   = absv(MUL_B_W'(r_row.sv));
                n_state = S_D1W;
            end
            S_D1W: begin
                n_lhs   = mul_p;
                n_state = S_D1C;
            end
            S_D1C: begin
                if (r_row.sc < CNT_W'(i_cfg.samples) || !dev) begin
                    n_state = S_SML;
                end else begin
                    n_res    = r_row.sv;
                    n_row.cl = inc_sat(r_row.cl);
                    n_state  = S_SHL;
                end
            end
            // Main smoothing step.
            S_SML: begin
                mul_a   = MUL_A_W'(i_cfg.alpha);
                mul_b   = diff(r_item.tsys, r_row.sv);
                n_state = S_SMW;
            end
            S_SMW: begin
                n_state = S_SMC;
            end
            S_SMC: begin
                sm       = smooth_add(mul_p, r_row.sv);
                n_res    = sm;
                n_row.sv = sm;
                n_row.cl = '0;
                n_row.sc = inc_sat(r_row.sc);
                n_state  = r_rej ? S_SHL : S_DONE;
            end
            // Shadow smoothing step.
            S_SHL: begin
                mul_a   = MUL_A_W'(i_cfg.alpha);
                mul_b   = diff(r_item.tsys, r_row.hv);
                n_state = S_SHW;
            end
            S_SHW: begin
                n_state = S_SHC;
            end
            S_SHC: begin
                n_row.hv = (r_row.hc != '0) ? smooth_add(mul_p, r_row.hv) : r_item.tsys;
                n_row.hc = inc_sat(r_row.hc);
                n_state  = (n_row.hc >= CNT_W'(i_cfg.samples)) ? S_D2L : S_DONE;
            end
            // Deviation of the shadow from the estimate.
            S_D2L: begin
                mul_a   = DEV_SCALE;
                mul_b   = absv(diff(r_row.hv, r_row.sv));
                n_state = S_D2R;
            end
            S_D2R: begin
                mul_a   = MUL_A_W'(r_item.threshold_pct);
                mul_b   = absv(MUL_B_W'(r_row.sv));
                n_state = S_D2W;
            end
            S_D2W: begin
                n_lhs   = mul_p;
                n_state = S_D2C;
            end
            S_D2C: begin
                if (dev && r_row.cl > CNT_W'(JUMP_CLIP_LIMIT)) begin
                    n_res    = r_row.hv;
                    n_row.sv = r_row.hv;
                    n_row.sc = r_row.hc;
                    n_row.cl = '0;
                    n_row.jm = 1'b1;
                    n_rec    = 1'b1;
                end
                n_row.hc = '0;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_DONE);

    always_comb begin
        o_res.channel_out = r_item.channel;
        o_res.tsys_out    = r_res;
        o_res.clip_count  = r_chok ? r_row.cl : '0;
        o_res.recovered   = r_rec;
    end

endmodule

`default_nettype wire

@@ src/tsys_smoothing_outlier_filter.sv @@
// Top level of the system-temperature smoothing filter: configuration
// registers, result register and the sequencer. Depends on tsof_pkg,
// tsof_if, tsof_seq and assert_macros.svh.
//
//   channel   direction  carries
//   i_in      in         cmd, channel, tsys, no_data, threshold_pct
//   o_out     out        channel_out, tsys_out, clip_count, recovered
//   i_cfg     in         index, data (samples, alpha, filter_mode)
//
// An item goes from decode straight to the result when it needs no
// multiplication, through the main smoothing step when it is only smoothed,
// and with outlier rejection through the deviation and shadow steps as well.
// After reset a clearing pass zeroes every row of the state memory
// before the first item is taken; configuration writes are taken at once.
// A stalled result holds one result register; the sequencer waits for it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tsys_smoothing_outlier_filter #(
    parameter int CHANNELS        = tsof_pkg::CHANNELS_DEF,
    parameter int JUMP_CLIP_LIMIT = tsof_pkg::JUMP_LIMIT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tsof_in_if.sink     i_in,
    tsof_out_if.source  o_out,
    tsof_cfg_if.sink    i_cfg
);
    import tsof_pkg::*;

    t_cfg  r_cfg;
    t_item item;
    t_res  seq_res;
    t_res  r_out;
    logic  r_out_valid;
    logic  seq_valid;
    logic  out_free;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.samples <= SAMPLES_RST;
            r_cfg.alpha   <= ALPHA_RST;
            r_cfg.mode    <= MODE_ALWAYS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SAMPLES: r_cfg.samples <= i_cfg.data[SAMP_W-1:0];
                REG_ALPHA:   r_cfg.alpha   <= i_cfg.data[ALPHA_W-1:0];
                REG_MODE:    r_cfg.mode    <= i_cfg.data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        item.cmd           = i_in.cmd;
        item.channel       = i_in.channel;
        item.tsys          = i_in.tsys;
        item.no_data       = i_in.no_data;
        item.threshold_pct = i_in.threshold_pct;
    end

    tsof_seq #(
        .CHANNELS        (CHANNELS),
        .JUMP_CLIP_LIMIT (JUMP_CLIP_LIMIT)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (item),
        .o_valid (seq_valid),
        .i_ready (out_free),
        .o_res   (seq_res)
    );

    // Result register.
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= seq_valid;
        end
        if (out_free && seq_valid) begin
            r_out <= seq_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.channel_out = r_out.channel_out;
    assign o_out.tsys_out    = r_out.tsys_out;
    assign o_out.clip_count  = r_out.clip_count;
    assign o_out.recovered   = r_out.recovered;

    // A recovery always restarts the clip count.
    `ASSERT_SAME(a_recover_clears, i_clk, i_rst_n, o_out.valid && o_out.recovered, o_out.clip_count == '0)
    // One item at a time: the input closes right after a transaction.
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // A result is only loaded into the result register when it is free.
    `ASSERT_NEXT(a_no_overwrite, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid)

endmodule

`default_nettype wire
